### sv/template_slot_table_allocator_unit_macros.svh
// Assertion macros shared by the slot table allocator RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef TEMPLATE_SLOT_TABLE_ALLOCATOR_UNIT_MACROS_SVH
`define TEMPLATE_SLOT_TABLE_ALLOCATOR_UNIT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define TSTA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("slot table allocator check failed");

// Checks that a condition never holds outside reset.
`define TSTA_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("slot table allocator check failed");

`endif

### sv/tsta_pkg.sv
// Package for the slot table allocator: sizes, codes and the structs that
// pass between controller and datapath. Depends on nothing.
package tsta_pkg;

   localparam int SLOTS            = 128;
   localparam int SECTOR_MAP_BYTES = 20;
   localparam int SECTOR_BITS      = SECTOR_MAP_BYTES * 8;
   localparam int SLOT_W           = $clog2(SLOTS);
   localparam int SEC_W            = $clog2(SECTOR_BITS);
   // One step past the last sector bit and the last slot read, so the
   // trackers are settled in the cycle that ends the scan.
   localparam int SCAN_END = ((SECTOR_BITS - 1 > SLOTS) ? SECTOR_BITS - 1 : SLOTS) + 1;
   localparam int CNT_W    = $clog2(SCAN_END + 1);

   localparam logic [15:0] UPD_MAX    = 16'hfffe;
   localparam logic [7:0]  MEMBER_MAX = 8'h64;
   localparam logic [15:0] MAX_LEN_RESET = 16'd12284;

   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_ADDR_INIT_UPD = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_ADDR_MAX_LEN  = 3'd4;

   localparam logic [2:0] OP_STORE      = 3'd0;
   localparam logic [2:0] OP_DEL_KEY    = 3'd1;
   localparam logic [2:0] OP_DEL_MEMBER = 3'd2;
   localparam logic [2:0] OP_LOOKUP     = 3'd3;
   localparam logic [2:0] OP_READ       = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_PARAM     = 3'd1;
   localparam logic [2:0] ST_NOT_FOUND = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_BAD_LEN   = 3'd4;

   typedef struct packed {
      logic [7:0]  key;
      logic [7:0]  sector;
      logic [15:0] length;
      logic [7:0]  member;
      logic [15:0] updates;
   } entry_type;

   typedef struct packed {
      logic load;
      logic check;
      logic scan;
      logic fetch;
      logic apply;
   } cmd_type;

   typedef struct packed {
      logic scan_needed;
      logic fetch_needed;
      logic scan_done;
   } stat_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  found_slot;
      logic [7:0]  sector;
      logic [15:0] stored_length;
      logic [7:0]  stored_member;
      logic        key_present;
      logic [7:0]  entry_count;
      logic [15:0] update_count;
   } result_type;

endpackage

### sv/tsta_ctrl.sv
// Controller state machine of the slot table allocator.
// Depends on tsta_pkg and the assertion macro header.
`include "template_slot_table_allocator_unit_macros.svh"

module tsta_ctrl
   import tsta_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     rsp_free,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     emit
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_CHECK = 6'b000010,
      S_SCAN  = 6'b000100,
      S_FETCH = 6'b001000,
      S_APPLY = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      emit      = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.scan_needed) state_in = S_SCAN;
            else if (stat.fetch_needed) state_in = S_FETCH;
            else state_in = S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = stat.fetch_needed ? S_FETCH : S_DONE;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            emit = rsp_free;
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   `TSTA_ASSERT(a_accept_checks, clock, reset, (req_valid && req_ready) |=> (state_ff == S_CHECK))
   `TSTA_ASSERT(a_scan_ends, clock, reset, (state_ff == S_SCAN && !stat.scan_done) |=> (state_ff == S_SCAN))
   `TSTA_NEVER(a_emit_idle, clock, reset, emit && (state_ff != S_DONE))

endmodule

### sv/tsta_dp.sv
// Datapath of the slot table allocator: slot memory, bitmaps, scan trackers
// and result formation. Depends on tsta_pkg and the assertion macro header.
`include "template_slot_table_allocator_unit_macros.svh"

module tsta_dp
   import tsta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_key_id,
   input  logic [7:0]  req_member_number,
   input  logic [15:0] req_record_length,
   input  logic [7:0]  req_slot_index,
   input  logic [15:0] init_upd,
   input  logic [15:0] max_len,
   output stat_type    stat,
   output result_type  result
);

   // Request, captured at acceptance.
   logic [2:0]  op_ff;
   logic [7:0]  key_ff, mem_ff, sidx_ff;
   logic [15:0] len_ff;

   // Per-slot flags, bitmaps and count.
   logic [SLOTS-1:0]       used_ff, used_in, wrt_ff, wrt_in;
   logic [SECTOR_BITS-1:0] smap_ff, smap_in;
   logic [255:0]           kmap_ff, kmap_in;
   logic [7:0]             count_ff, count_in;

   // Scan trackers.
   logic [CNT_W-1:0]  cnt_ff;
   logic              pvld_ff;
   logic [SLOT_W-1:0] pidx_ff;
   logic              secf_ff, matchf_ff, freef_ff;
   logic [SEC_W-1:0]  sec_ff;
   logic [SLOT_W-1:0] match_ff, free_ff;

   entry_type         slot_mem [SLOTS];
   entry_type         rdq_ff, ent, wr_data, res_ff, res_in;
   logic              wr_en;
   logic [SLOT_W-1:0] rd_addr, tgt;

   logic is_store, is_delk, is_delm, is_look, is_read, pre_err, post_err;
   logic scan_hit_used, delm_hit;
   logic [15:0] upd_next;
   logic [2:0]  status;

   assign is_store = (op_ff == OP_STORE);
   assign is_delk  = (op_ff == OP_DEL_KEY);
   assign is_delm  = (op_ff == OP_DEL_MEMBER);
   assign is_look  = (op_ff == OP_LOOKUP);
   assign is_read  = (op_ff == OP_READ);

   assign pre_err = (op_ff > OP_CLEAR)
      || (is_store && (len_ff == 16'd0 || len_ff > max_len))
      || (is_delm && (mem_ff == 8'd0 || mem_ff > MEMBER_MAX))
      || (is_read && (int'(sidx_ff) >= SLOTS || !used_ff[sidx_ff[SLOT_W-1:0]]));

   assign post_err = (is_store && (!secf_ff || int'(sec_ff) > SLOTS + 1
                                   || (!matchf_ff && !freef_ff)))
      || ((is_delk || is_look) && !matchf_ff);

   assign stat.scan_needed  = !pre_err && (is_store || is_delk || is_delm || is_look);
   assign stat.fetch_needed = !pre_err && (is_read || ((is_store || is_delk || is_look) && !post_err));
   assign stat.scan_done    = (cnt_ff == CNT_W'(SCAN_END));

   assign tgt = is_read ? sidx_ff[SLOT_W-1:0] :
                (is_store && !matchf_ff) ? free_ff : match_ff;
   assign rd_addr = cmd.scan ? cnt_ff[SLOT_W-1:0] : (cmd.fetch || cmd.apply ? tgt : pidx_ff);

   // An entry never written since reset or clear reads as zero.
   assign ent = wrt_ff[cmd.scan ? pidx_ff : tgt] ? rdq_ff : '0;
   assign scan_hit_used = cmd.scan && pvld_ff && used_ff[pidx_ff];
   assign delm_hit = scan_hit_used && is_delm && (ent.member == mem_ff);
   assign upd_next = (ent.updates >= UPD_MAX) ? UPD_MAX : ent.updates + 16'd1;

   always_comb begin
      used_in  = used_ff;
      wrt_in   = wrt_ff;
      smap_in  = smap_ff;
      kmap_in  = kmap_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      wr_data  = ent;
      res_in   = res_ff;
      if (delm_hit) begin
         used_in[pidx_ff] = 1'b0;
         wrt_in[pidx_ff]  = 1'b0;
         kmap_in[ent.key] = 1'b0;
         if (int'(ent.sector) < SECTOR_BITS) smap_in[ent.sector[SEC_W-1:0]] = 1'b0;
         if (count_ff != 8'd0) count_in = count_ff - 8'd1;
      end
      if (cmd.apply) begin
         res_in = ent;
         if (is_store) begin
            if (matchf_ff) begin
               if (int'(ent.sector) < SECTOR_BITS) smap_in[ent.sector[SEC_W-1:0]] = 1'b0;
               wr_data.updates = upd_next;
            end else begin
               wr_data.updates = init_upd;
               count_in = count_ff + 8'd1;
            end
            wr_data.key    = key_ff;
            wr_data.sector = 8'(sec_ff);
            wr_data.length = len_ff;
            if (mem_ff != 8'd0) wr_data.member = mem_ff;
            smap_in[sec_ff] = 1'b1;
            kmap_in[key_ff] = 1'b1;
            used_in[tgt]    = 1'b1;
            wrt_in[tgt]     = 1'b1;
            wr_en           = 1'b1;
            res_in          = wr_data;
         end else if (is_delk) begin
            wr_data.key    = 8'd0;
            wr_data.sector = 8'd0;
            wr_data.length = 16'd0;
            kmap_in[ent.key] = 1'b0;
            if (int'(ent.sector) < SECTOR_BITS) smap_in[ent.sector[SEC_W-1:0]] = 1'b0;
            if (count_ff != 8'd0) count_in = count_ff - 8'd1;
            used_in[tgt] = 1'b0;
            wrt_in[tgt]  = 1'b1;
            wr_en        = 1'b1;
            res_in       = wr_data;
         end
      end
      if (cmd.check && op_ff == OP_CLEAR) begin
         used_in  = '0;
         wrt_in   = '0;
         smap_in  = '0;
         kmap_in  = '0;
         count_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) slot_mem[tgt] <= wr_data;
      rdq_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         wrt_ff   <= '0;
         smap_ff  <= '0;
         kmap_ff  <= '0;
         count_ff <= 8'd0;
         pvld_ff  <= 1'b0;
      end else begin
         used_ff  <= used_in;
         wrt_ff   <= wrt_in;
         smap_ff  <= smap_in;
         kmap_ff  <= kmap_in;
         count_ff <= count_in;
         pvld_ff  <= cmd.scan && (int'(cnt_ff) < SLOTS);
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      pidx_ff <= cnt_ff[SLOT_W-1:0];
      if (cmd.load) begin
         op_ff   <= req_op;
         key_ff  <= req_key_id;
         mem_ff  <= req_member_number;
         len_ff  <= req_record_length;
         sidx_ff <= req_slot_index;
      end
      if (cmd.check) begin
         cnt_ff    <= '0;
         secf_ff   <= 1'b0;
         matchf_ff <= 1'b0;
         freef_ff  <= 1'b0;
      end else if (cmd.scan) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (int'(cnt_ff) < SECTOR_BITS && !secf_ff && !smap_ff[cnt_ff[SEC_W-1:0]]) begin
            secf_ff <= 1'b1;
            sec_ff  <= cnt_ff[SEC_W-1:0];
         end
         if (scan_hit_used && ent.key == key_ff && !matchf_ff) begin
            matchf_ff <= 1'b1;
            match_ff  <= pidx_ff;
         end
         if (pvld_ff && !used_ff[pidx_ff] && !freef_ff) begin
            freef_ff <= 1'b1;
            free_ff  <= pidx_ff;
         end
      end
   end

   always_comb begin
      if (pre_err) status = ST_PARAM;
      else if (post_err) status = is_store ? ST_FULL : ST_NOT_FOUND;
      else if (is_read && res_ff.length > max_len) status = ST_BAD_LEN;
      else status = ST_OK;
   end

   always_comb begin
      result = '0;
      result.status      = status;
      result.key_present = kmap_ff[key_ff];
      result.entry_count = count_ff;
      if (status == ST_OK && (is_store || is_delk || is_look || is_read)) begin
         result.found_slot    = 7'(tgt);
         result.sector        = res_ff.sector;
         result.stored_length = res_ff.length;
         result.stored_member = res_ff.member;
         result.update_count  = res_ff.updates;
      end
   end

   `TSTA_ASSERT(a_count_matches, clock, reset, $countones(used_ff) == int'(count_ff))
   `TSTA_NEVER(a_used_written, clock, reset, (used_ff & ~wrt_ff) != '0)
   `TSTA_NEVER(a_count_range, clock, reset, int'(count_ff) > SLOTS)

endmodule

### sv/template_slot_table_allocator_unit.sv
// Slot table allocator. Each request word carries an operation (store,
// delete key, delete member, lookup, read slot, clear all) with its key,
// member, length and slot index; each request yields exactly one response
// word with status, slot contents, the key's presence bit and the entry count.
// Both channels use valid/ready; a word moves when both are high.
// Read slot, clear all and rejected requests skip the scan. Store, delete
// key, delete member and lookup scan the sector bitmap and all slots; store,
// delete key and lookup then fetch and apply when they go on to touch a slot.
// The scan walks one slot-memory read and one sector bit per cycle. One
// request is worked at a time: a new request is taken only after the last
// one's response has been written.
// The response register frees the datapath: a new request is accepted while a
// finished response still waits, and a stalled receiver only holds the block
// when the next response is ready to be written.
// Reset (synchronous, active high) empties the table, all bitmaps and the
// count at once; no clearing pass is needed. initial_update_time resets to 0
// and max_length to 12284. Configuration must be written through the APB port
// at byte addresses 0 and 4 while the block is idle; it does not check this.
`include "template_slot_table_allocator_unit_macros.svh"

module template_slot_table_allocator_unit
   import tsta_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_op,
   input  logic [7:0]        req_key_id,
   input  logic [7:0]        req_member_number,
   input  logic [15:0]       req_record_length,
   input  logic [7:0]        req_slot_index,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [6:0]        rsp_found_slot,
   output logic [7:0]        rsp_sector,
   output logic [15:0]       rsp_stored_length,
   output logic [7:0]        rsp_stored_member,
   output logic              rsp_key_present,
   output logic [7:0]        rsp_entry_count,
   output logic [15:0]       rsp_update_count,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [15:0] init_upd_ff, max_len_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff, result;
   cmd_type     cmd;
   stat_type    stat;
   logic        emit, rsp_free, csr_wr;

   // Configuration registers. Writes land in the access phase.
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_upd_ff <= 16'd0;
         max_len_ff  <= MAX_LEN_RESET;
      end else if (csr_wr) begin
         if (csr_paddr == CSR_ADDR_INIT_UPD) init_upd_ff <= csr_pwdata[15:0];
         if (csr_paddr == CSR_ADDR_MAX_LEN) max_len_ff <= csr_pwdata[15:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr == CSR_ADDR_INIT_UPD) csr_prdata = {16'd0, init_upd_ff};
      else if (csr_paddr == CSR_ADDR_MAX_LEN) csr_prdata = {16'd0, max_len_ff};
   end

   // The response register can take a new word when empty or being drained.
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (emit) rsp_ff <= result;
   end

   tsta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_free  (rsp_free),
      .stat      (stat),
      .cmd       (cmd),
      .emit      (emit)
   );

   tsta_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_op            (req_op),
      .req_key_id        (req_key_id),
      .req_member_number (req_member_number),
      .req_record_length (req_record_length),
      .req_slot_index    (req_slot_index),
      .init_upd          (init_upd_ff),
      .max_len           (max_len_ff),
      .stat              (stat),
      .result            (result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_found_slot    = rsp_ff.found_slot;
   assign rsp_sector        = rsp_ff.sector;
   assign rsp_stored_length = rsp_ff.stored_length;
   assign rsp_stored_member = rsp_ff.stored_member;
   assign rsp_key_present   = rsp_ff.key_present;
   assign rsp_entry_count   = rsp_ff.entry_count;
   assign rsp_update_count  = rsp_ff.update_count;

   `TSTA_NEVER(a_no_overwrite, clock, reset, emit && rsp_valid_ff && !rsp_ready)
   `TSTA_ASSERT(a_accept_blocks, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `TSTA_NEVER(a_bad_status, clock, reset, rsp_valid_ff && rsp_ff.status > ST_BAD_LEN)

endmodule
